// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers; they expand to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// plain property, sampled on the rising edge, off during reset
`define FHT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define FHT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FHT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define FHT_ASSERT(lbl, clk, rst, prop, msg)
`define FHT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define FHT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== sv/fht_pkg.sv =====
// ----------------------------------------------------------------------------
// fht_pkg
// Shared types and constants of the FIR Hilbert transformer.
// ----------------------------------------------------------------------------
package fht_pkg;

  localparam int NTAPS_DEF  = 31;
  localparam int DATA_W     = 16;
  localparam int COEF_IDX_W = 5;
  localparam int FRAC_W     = 15;

  localparam logic signed [DATA_W-1:0] Q_MAX = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 16'sh8000;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  // request travelling down the cell chain
  typedef struct packed {
    logic                     valid;
    op_t                      op;
    logic signed [DATA_W-1:0] data;  // sample / displaced history / coefficient
    logic [COEF_IDX_W-1:0]    idx;
    logic signed [DATA_W-1:0] mid;   // center tap, becomes in_phase
  } tok_t;

endpackage

// ===== sv/fir_hilbert_transformer_unit.sv =====
// ----------------------------------------------------------------------------
// fir_hilbert_transformer_unit
// Pipeline: one register per tap cell, the first loaded at the accepting edge,
// then the rounding register, which raises out_valid and holds the result.
// Throughput: one request per cycle while the chain is not stalled; coefficient loads take one slot, no result.
// The chain stalls only while a finished sample waits behind a held result.
// Reset clears history, weights and all valid flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fir_hilbert_transformer_unit #(
  parameter int NTAPS = fht_pkg::NTAPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic signed [fht_pkg::DATA_W-1:0]   sample_in,
  input  logic [fht_pkg::COEF_IDX_W-1:0]      coef_index,
  input  logic signed [fht_pkg::DATA_W-1:0]   coef_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fht_pkg::DATA_W-1:0]   in_phase,
  output logic signed [fht_pkg::DATA_W-1:0]   quadrature,
  output logic                                saturated
);
  import fht_pkg::*;

  localparam int ACC_W  = 2 * DATA_W + $clog2(NTAPS);
  localparam int CENTER = NTAPS / 2;

  tok_t                    tok [NTAPS+1];
  logic signed [ACC_W-1:0] acc [NTAPS+1];
  logic                    adv;
  op_t                     op;

  assign op = op_t'(opcode);

  // whole chain moves together unless a finished sample is blocked
  assign adv = !(tok[NTAPS].valid && (tok[NTAPS].op == OP_SAMPLE) && out_valid && !out_ready);
  assign in_ready = adv;

  assign tok[0] = '{valid: in_valid,
                    op:    op,
                    data:  (op == OP_LOAD) ? coef_value : sample_in,
                    idx:   coef_index,
                    mid:   '0};
  assign acc[0] = '0;

  for (genvar k = 0; k < NTAPS; k++) begin : g_cell
    fht_cell #(
      .ACC_W  (ACC_W),
      .IDX    (k),
      .CENTER (k == CENTER)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (tok[k]),
      .acc_in  (acc[k]),
      .tok_out (tok[k+1]),
      .acc_out (acc[k+1])
    );
  end

  fht_round #(
    .ACC_W (ACC_W)
  ) u_round (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .tok        (tok[NTAPS]),
    .acc        (acc[NTAPS]),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .in_phase   (in_phase),
    .quadrature (quadrature),
    .saturated  (saturated)
  );

  `FHT_ASSERT_IMP(a_stall_cause, clk, rst, !in_ready, out_valid && !out_ready, "stall without a held result")
  `FHT_ASSERT_NXT(a_stall_holds, clk, rst, !adv, $stable(tok[NTAPS]) && $stable(acc[NTAPS]), "chain moved during stall")
  `FHT_ASSERT_NXT(a_result_lands, clk, rst, adv && tok[NTAPS].valid && tok[NTAPS].op == OP_SAMPLE, out_valid, "finished sample lost")
  `FHT_ASSERT_IMP(a_sat_extreme, clk, rst, out_valid && saturated, quadrature == Q_MAX || quadrature == Q_MIN, "saturated flag on in-range value")

endmodule

// ===== sv/fht_cell.sv =====
// ----------------------------------------------------------------------------
// fht_cell
// One tap: holds a history sample and a weight, does one MAC per request.
// ----------------------------------------------------------------------------
module fht_cell #(
  parameter int ACC_W  = 37,
  parameter int IDX    = 0,
  parameter bit CENTER = 1'b0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  fht_pkg::tok_t            tok_in,
  input  logic signed [ACC_W-1:0]  acc_in,
  output fht_pkg::tok_t            tok_out,
  output logic signed [ACC_W-1:0]  acc_out
);
  import fht_pkg::*;

  localparam bit ADDRESSABLE = (IDX < (1 << COEF_IDX_W));

  logic                       vld;
  op_t                        pay_op;
  logic signed [DATA_W-1:0]   pay_data;
  logic [COEF_IDX_W-1:0]      pay_idx;
  logic signed [DATA_W-1:0]   pay_mid;
  logic signed [DATA_W-1:0]   weight;
  logic signed [DATA_W-1:0]   hist;
  logic signed [2*DATA_W-1:0] prod;
  logic                       hit;
  logic                       is_sample;

  assign hit       = ADDRESSABLE && (tok_in.idx == COEF_IDX_W'(IDX));
  assign is_sample = tok_in.valid && (tok_in.op == OP_SAMPLE);
  assign prod      = weight * tok_in.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= 1'b0;
      weight <= '0;
      hist   <= '0;
    end else if (adv) begin
      vld <= tok_in.valid;
      if (tok_in.valid && tok_in.op == OP_LOAD && hit) begin
        weight <= tok_in.data;
      end
      if (is_sample) begin
        hist <= tok_in.data;
      end
    end
  end

  // sample swaps with local history; the older sample moves on to the next tap
  always_ff @(posedge clk) begin
    if (adv) begin
      pay_op   <= tok_in.op;
      pay_idx  <= tok_in.idx;
      pay_data <= is_sample ? hist : tok_in.data;
      pay_mid  <= (CENTER && is_sample) ? tok_in.data : tok_in.mid;
      acc_out  <= acc_in + ACC_W'(prod);
    end
  end

  assign tok_out = '{valid: vld, op: pay_op, data: pay_data, idx: pay_idx, mid: pay_mid};

endmodule

// ===== sv/fht_round.sv =====
// ----------------------------------------------------------------------------
// fht_round
// Rounds the chain sum from Q15, saturates, and holds the result request.
// ----------------------------------------------------------------------------
module fht_round #(
  parameter int ACC_W = 37
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  fht_pkg::tok_t                   tok,
  input  logic signed [ACC_W-1:0]         acc,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic signed [fht_pkg::DATA_W-1:0] in_phase,
  output logic signed [fht_pkg::DATA_W-1:0] quadrature,
  output logic                            saturated
);
  import fht_pkg::*;

  localparam int TOP = FRAC_W + DATA_W - 1;

  logic signed [ACC_W:0]      s;
  logic                       ovf;
  logic signed [DATA_W-1:0]   q_next;
  logic                       load;

  // floor((acc + 2^14) / 2^15); in range when the upper bits are pure sign
  assign s      = (ACC_W+1)'(acc) + (ACC_W+1)'(1 << (FRAC_W - 1));
  assign ovf    = !((&s[ACC_W:TOP]) || !(|s[ACC_W:TOP]));
  assign q_next = ovf ? (s[ACC_W] ? Q_MIN : Q_MAX) : s[TOP:FRAC_W];
  assign load   = adv && tok.valid && (tok.op == OP_SAMPLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      in_phase   <= tok.mid;
      quadrature <= q_next;
      saturated  <= ovf;
    end
  end

endmodule

// ===== dv/tb_fir_hilbert_transformer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_fir_hilbert_transformer_unit
// Self-checking bench for the FIR Hilbert transformer. Sample and coefficient
// load requests go in through a queued driver with random gaps. The bench
// predicts the delayed in-phase sample and the rounded, saturated quadrature
// sum, and checks every result against them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fir_hilbert_transformer_unit;
  import fht_pkg::*;

  localparam int NTAPS          = NTAPS_DEF;
  localparam int CENTER         = NTAPS / 2;
  localparam int TAIL_CYCLES    = 2 * (NTAPS + 1) + 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 1950;
  localparam int MAX_PRINTED    = 100;
  localparam real PI            = 3.14159265358979;

  typedef struct {
    op_t                      op;
    logic signed [DATA_W-1:0] smp;
    logic [COEF_IDX_W-1:0]    idx;
    logic signed [DATA_W-1:0] coef;
    bit                       drain_first;  // hold until all results are back
  } hilb_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] iph;
    logic signed [DATA_W-1:0] quad;
    logic                     sat;
  } analytic_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic opcode = OP_SAMPLE;
  logic signed [DATA_W-1:0] sample_in = '0;
  logic [COEF_IDX_W-1:0] coef_index = '0;
  logic signed [DATA_W-1:0] coef_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] in_phase;
  logic signed [DATA_W-1:0] quadrature;
  logic saturated;

  hilb_req_t req_q[$];
  analytic_t analytic_q[$];

  logic signed [DATA_W-1:0] hist_mirror [NTAPS];
  logic signed [DATA_W-1:0] weight_mirror [NTAPS];

  hilb_req_t cur_req;
  bit in_flight = 1'b0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned stall_cycles = 0;
  int unsigned err_cnt = 0;
  int unsigned live_items = 0;
  bit hold_for_drain = 1'b0;

  fir_hilbert_transformer_unit #(.NTAPS(NTAPS)) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .sample_in  (sample_in),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .in_phase   (in_phase),
    .quadrature (quadrature),
    .saturated  (saturated)
  );

  always #5 clk = ~clk;

  function automatic int unsigned idle_cycles(bit burst);
    if (burst) return 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic flag_mismatch(input string what);
    if (err_cnt < MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, what);
    err_cnt++;
  endtask

  task automatic queue_request(input op_t op, input logic signed [DATA_W-1:0] smp,
                               input logic [COEF_IDX_W-1:0] idx,
                               input logic signed [DATA_W-1:0] coef);
    hilb_req_t r;
    r.op          = op;
    r.smp         = smp;
    r.idx         = idx;
    r.coef        = coef;
    r.drain_first = hold_for_drain;
    hold_for_drain = 1'b0;
    req_q.push_back(r);
    if (!(op == OP_LOAD && idx >= NTAPS)) live_items++;
  endtask

  // shift, FIR sum, round half up from Q15, clip
  task automatic apply_request(input hilb_req_t r);
    longint acc;
    longint q;
    analytic_t e;
    if (r.op == OP_LOAD) begin
      if (r.idx < NTAPS) weight_mirror[r.idx] = r.coef;
    end else begin
      for (int k = NTAPS - 1; k > 0; k--) hist_mirror[k] = hist_mirror[k-1];
      hist_mirror[0] = r.smp;
      acc = 0;
      for (int k = 0; k < NTAPS; k++)
        acc += longint'(weight_mirror[k]) * longint'(hist_mirror[k]);
      q = (acc + 16384) >>> FRAC_W;
      e.sat = 1'b0;
      if (q > 32767) begin
        q = 32767;
        e.sat = 1'b1;
      end else if (q < -32768) begin
        q = -32768;
        e.sat = 1'b1;
      end
      e.iph  = hist_mirror[CENTER];
      e.quad = q[DATA_W-1:0];
      analytic_q.push_back(e);
    end
  endtask

  initial begin
    for (int k = 0; k < NTAPS; k++) begin
      hist_mirror[k]   = '0;
      weight_mirror[k] = '0;
    end
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request(cur_req);
        in_flight = 1'b0;
        if ($urandom_range(0, 63) == 0) send_burst = ~send_burst;
        send_gap = idle_cycles(send_burst);
      end
      if (!in_flight) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (req_q.size() > 0 &&
                     !(req_q[0].drain_first && analytic_q.size() != 0)) begin
          cur_req = req_q.pop_front();
          in_flight = 1'b1;
          opcode     <= cur_req.op;
          sample_in  <= cur_req.smp;
          coef_index <= cur_req.idx;
          coef_value <= cur_req.coef;
        end
      end
      in_valid <= in_flight;
    end
  end

  // result monitor
  always @(posedge clk) begin : result_check
    analytic_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (analytic_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result iph=%0d quad=%0d sat=%0b",
                                  in_phase, quadrature, saturated));
        end else begin
          e = analytic_q.pop_front();
          if (in_phase !== e.iph)
            flag_mismatch($sformatf("in_phase %0d, want %0d", in_phase, e.iph));
          if (quadrature !== e.quad)
            flag_mismatch($sformatf("quadrature %0d, want %0d", quadrature, e.quad));
          if (saturated !== e.sat)
            flag_mismatch($sformatf("saturated %0b, want %0b", saturated, e.sat));
        end
        if ($urandom_range(0, 63) == 0) recv_burst = ~recv_burst;
        recv_gap = idle_cycles(recv_burst);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int kind;
    int len;
    int d;
    int v;
    real gain;
    real w;
    real amp;
    real x;
    logic signed [DATA_W-1:0] s;

    // weights all zero: quadrature must be zero
    queue_request(OP_SAMPLE, 16'sh7FFF, '0, '0);
    queue_request(OP_SAMPLE, 16'sh8000, 5'd31, 16'sh7FFF);
    // out-of-range index is dropped
    queue_request(OP_LOAD, '0, 5'd31, 16'sh7FFF);
    queue_request(OP_LOAD, '0, 5'd0, 16'sh7FFF);
    queue_request(OP_LOAD, '0, 5'd30, 16'sh8000);
    queue_request(OP_LOAD, '0, 5'(CENTER), 16'sh7FFF);
    // new sample lands in the history before the sum
    queue_request(OP_SAMPLE, 16'sh7FFF, '0, '0);
    queue_request(OP_LOAD, '0, 5'd1, 16'sh7FFF);
    queue_request(OP_LOAD, '0, 5'd2, 16'sh7FFF);
    queue_request(OP_SAMPLE, 16'sh7FFF, '0, '0);
    queue_request(OP_SAMPLE, 16'sh7FFF, '0, '0);
    queue_request(OP_SAMPLE, 16'sh8000, '0, '0);
    queue_request(OP_SAMPLE, 16'sh8000, '0, '0);
    queue_request(OP_SAMPLE, 16'sh8000, '0, '0);
    // rounding at the half step, both signs
    hold_for_drain = 1'b1;
    queue_request(OP_LOAD, '0, 5'd0, 16'sh0001);
    queue_request(OP_LOAD, '0, 5'd1, 16'sh0000);
    queue_request(OP_LOAD, '0, 5'd2, 16'sh0000);
    queue_request(OP_LOAD, '0, 5'd30, 16'sh0000);
    queue_request(OP_LOAD, '0, 5'(CENTER), 16'sh0000);
    queue_request(OP_SAMPLE, 16'sh4000, '0, '0);
    queue_request(OP_SAMPLE, -16'sh4000, '0, '0);
    queue_request(OP_SAMPLE, -16'sh4001, '0, '0);
    queue_request(OP_SAMPLE, 16'sh0000, '0, '0);
    queue_request(OP_SAMPLE, 16'shFFFF, '0, '0);

    while (live_items < ITEM_TARGET) begin
      hold_for_drain = ($urandom_range(0, 2) == 0);
      kind = $urandom_range(0, 3);
      if (kind == 0) begin
        // windowed Hilbert taps, zero at even offsets from the center
        gain = 0.5 + $urandom_range(0, 100) / 100.0;
        for (int k = 0; k < NTAPS; k++) begin
          d = k - CENTER;
          v = 0;
          if (d % 2 != 0) begin
            x = gain * 65536.0 / (PI * d) * (0.54 + 0.46 * $cos(PI * d / (CENTER + 1)));
            v = $rtoi(x);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
          end
          queue_request(OP_LOAD, '0, 5'(k), 16'(v));
        end
      end else if (kind == 1) begin
        for (int k = 0; k < NTAPS; k++)
          queue_request(OP_LOAD, '0, 5'(k), 16'($urandom));
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          queue_request(OP_LOAD, '0, 5'($urandom_range(0, 31)), 16'($urandom));
      end

      len  = $urandom_range(20, 120);
      kind = $urandom_range(0, 3);
      w    = $urandom_range(1, 300) / 1000.0;
      amp  = $urandom_range(100, 32767);
      for (int n = 0; n < len; n++) begin
        if ($urandom_range(0, 99) < 6) begin
          queue_request(OP_LOAD, '0, 5'($urandom_range(0, 31)), 16'($urandom));
        end
        case (kind)
          0: s = 16'($urandom);
          1: s = 16'($urandom_range(0, 2000) - 1000);
          2: begin
            case ($urandom_range(0, 4))
              0: s = 16'sh7FFF;
              1: s = 16'sh8000;
              2: s = 16'sh0000;
              3: s = 16'shFFFF;
              default: s = 16'sh0001;
            endcase
          end
          default: s = 16'($rtoi(amp * $sin(w * n)));
        endcase
        queue_request(OP_SAMPLE, s, 5'($urandom), 16'($urandom));
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (req_q.size() != 0 || in_flight) @(posedge clk);
    while (analytic_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
